/* hw/rtl/pkrt_pkg.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkrt_pkg
// Shared types and constants for the held-key table with typematic repeat.
// ----------------------------------------------------------------------------
package pkrt_pkg;

   localparam int TYPE_W = 3;
   localparam int KEY_W  = 8;
   localparam int MOD_W  = 5;
   localparam int AGE_W  = 9;
   localparam int CFG_W  = 8;
   localparam int CSR_IDX_W = 1;

   // restoring modulo: one dividend bit per step
   localparam int MOD_STEPS  = AGE_W;
   localparam int MOD_STEP_W = $clog2(MOD_STEPS + 1);

   localparam logic [TYPE_W-1:0] REQ_PRESS   = 3'd0;
   localparam logic [TYPE_W-1:0] REQ_RELEASE = 3'd1;
   localparam logic [TYPE_W-1:0] REQ_TICK    = 3'd2;
   localparam logic [TYPE_W-1:0] REQ_MODS    = 3'd3;
   localparam logic [TYPE_W-1:0] REQ_LEAVE   = 3'd4;

   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_DELAY  = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_REPEAT_PERIOD = 1'b1;

   localparam logic [CFG_W-1:0] DELAY_RESET  = 8'd50;
   localparam logic [CFG_W-1:0] PERIOD_RESET = 8'd5;

   localparam logic [KEY_W-1:0] KEYPAD_LO = 8'h53;
   localparam logic [KEY_W-1:0] KEYPAD_HI = 8'h63;

   localparam logic [MOD_W-1:0] M_SHIFT = 5'h01;
   localparam logic [MOD_W-1:0] M_CAPS  = 5'h02;
   localparam logic [MOD_W-1:0] M_CTRL  = 5'h04;
   localparam logic [MOD_W-1:0] M_ALT   = 5'h08;
   localparam logic [MOD_W-1:0] M_NUM   = 5'h10;

   // controller -> datapath
   typedef struct packed {
      logic capture;
      logic set_mods;
      logic clear_all;
      logic idx_clr;
      logic idx_inc;
      logic append;
      logic remove;
      logic age_wr;
      logic use_mod;
      logic fire_take;
      logic mod_load;
      logic mod_step;
      logic flush;
   } cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic at_end;
      logic match;
      logic full;
      logic fast;
      logic fire_fast;
      logic fire_mod;
      logic pend_valid;
      logic out_free;
   } stat_type;

   function automatic logic key_level(input logic [KEY_W-1:0] key,
                                      input logic [MOD_W-1:0] mods);
      logic lvl;
      if (key >= KEYPAD_LO && key <= KEYPAD_HI) begin
         lvl = |(mods & M_NUM);
      end else begin
         lvl = (|(mods & M_SHIFT)) ^ (|(mods & M_CAPS));
      end
      return lvl;
   endfunction

endpackage
`default_nettype wire

/* hw/rtl/pkrt_ctrl.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkrt_ctrl
// Sequencer: walks the key table for press/release search and tick aging;
// modifier update and focus leave act from idle.
module pkrt_ctrl import pkrt_pkg::*; (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   input  wire logic [TYPE_W-1:0] req_type,
   output logic                   req_stall,
   input  wire stat_type          stat,
   output cmd_type                cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SRCH,
      ST_AGE,
      ST_MOD,
      ST_FIN,
      ST_FLUSH
   } state_type;

   state_type             state_ff, state_in;
   logic                  press_ff, press_in;
   logic [MOD_STEP_W-1:0] step_ff, step_in;
   logic                  blocked;

   assign req_stall = (state_ff != ST_IDLE);

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      press_in = press_ff;
      step_in  = step_ff;
      blocked  = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               unique case (req_type)
                  REQ_PRESS, REQ_RELEASE: begin
                     cmd.capture = 1'b1;
                     cmd.idx_clr = 1'b1;
                     press_in    = (req_type == REQ_PRESS);
                     state_in    = ST_SRCH;
                  end
                  REQ_TICK: begin
                     cmd.idx_clr = 1'b1;
                     state_in    = ST_AGE;
                  end
                  REQ_MODS:  cmd.set_mods  = 1'b1;
                  REQ_LEAVE: cmd.clear_all = 1'b1;
                  default: ;
               endcase
            end
         end
         ST_SRCH: begin
            if (stat.at_end) begin
               cmd.append = press_ff && !stat.full;
               state_in   = ST_IDLE;
            end else if (stat.match) begin
               cmd.remove = !press_ff;
               state_in   = ST_IDLE;
            end else begin
               cmd.idx_inc = 1'b1;
            end
         end
         ST_AGE: begin
            if (stat.at_end) begin
               state_in = ST_FLUSH;
            end else if (!stat.fast) begin
               cmd.mod_load = 1'b1;
               step_in      = '0;
               state_in     = ST_MOD;
            end else begin
               blocked = stat.fire_fast && stat.pend_valid && !stat.out_free;
               if (!blocked) begin
                  cmd.age_wr    = 1'b1;
                  cmd.fire_take = stat.fire_fast;
                  cmd.idx_inc   = 1'b1;
               end
            end
         end
         ST_MOD: begin
            cmd.mod_step = 1'b1;
            step_in      = step_ff + 1'b1;
            if (step_ff == MOD_STEP_W'(MOD_STEPS - 1)) begin
               state_in = ST_FIN;
            end
         end
         ST_FIN: begin
            cmd.use_mod = 1'b1;
            blocked     = stat.fire_mod && stat.pend_valid && !stat.out_free;
            if (!blocked) begin
               cmd.age_wr    = 1'b1;
               cmd.fire_take = stat.fire_mod;
               cmd.idx_inc   = 1'b1;
               state_in      = ST_AGE;
            end
         end
         ST_FLUSH: begin
            // last held result goes out with its last flag set
            if (!(stat.pend_valid && !stat.out_free)) begin
               cmd.flush = 1'b1;
               state_in  = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         press_ff <= 1'b0;
         step_ff  <= '0;
      end else begin
         state_ff <= state_in;
         press_ff <= press_in;
         step_ff  <= step_in;
      end
   end

endmodule
`default_nettype wire

/* hw/rtl/pkrt_dp.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkrt_dp
// Key table, ages, modifier state, repeat registers, modulo unit and the
// pending / output result registers.
// ----------------------------------------------------------------------------
module pkrt_dp import pkrt_pkg::*; #(
   parameter int TABLE_DEPTH = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire cmd_type              cmd,
   output stat_type                  stat,
   input  wire logic [KEY_W-1:0]     req_key_code,
   input  wire logic [MOD_W-1:0]     req_held_mods,
   input  wire logic [MOD_W-1:0]     req_latched_mods,
   input  wire logic [MOD_W-1:0]     req_locked_mods,
   input  wire logic                 csr_write,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [KEY_W-1:0]          rsp_out_key,
   output logic [MOD_W-1:0]          rsp_out_mods,
   output logic                      rsp_level,
   output logic                      rsp_last
);

   localparam int CNT_W  = $clog2(TABLE_DEPTH + 1);
   localparam int SLOT_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;

   logic [KEY_W-1:0] slot_ff [TABLE_DEPTH];
   logic [AGE_W-1:0] age_ff  [TABLE_DEPTH];

   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [MOD_W-1:0] held_ff, held_in;
   logic [MOD_W-1:0] latched_ff, latched_in;
   logic [MOD_W-1:0] locked_ff, locked_in;
   logic [CFG_W-1:0] delay_ff, delay_in;
   logic [CFG_W-1:0] period_ff, period_in;
   logic             pend_valid_ff, pend_valid_in;
   logic             rsp_valid_ff, rsp_valid_in;

   logic [KEY_W-1:0] key_ff;
   logic [AGE_W-1:0] dvd_ff;
   logic [CFG_W-1:0] rem_ff;
   logic [KEY_W-1:0] pend_key_ff;
   logic [MOD_W-1:0] pend_mods_ff;
   logic             pend_level_ff;
   logic [KEY_W-1:0] rsp_key_ff;
   logic [MOD_W-1:0] rsp_mods_ff;
   logic             rsp_level_ff;
   logic             rsp_last_ff;

   logic [SLOT_W-1:0] sel;
   logic [KEY_W-1:0]  cur_key;
   logic [AGE_W-1:0]  cur_age;
   logic [AGE_W-1:0]  age_inc;
   logic [AGE_W-1:0]  delay_x;
   logic [AGE_W-1:0]  period_x;
   logic [AGE_W-1:0]  over;
   logic [AGE_W-1:0]  over_sub;
   logic              below;
   logic              lt_p;
   logic              lt_2p;
   logic [AGE_W-1:0]  fast_age;
   logic              fire_fast;
   logic [AGE_W-1:0]  mod_age;
   logic [AGE_W-1:0]  new_age;
   logic [AGE_W-1:0]  mod_trial;
   logic [MOD_W-1:0]  mods;
   logic              out_free;
   logic              push;

   assign sel     = idx_ff[SLOT_W-1:0];
   assign cur_key = slot_ff[sel];
   assign cur_age = age_ff[sel];

   // a zero register acts as one
   assign delay_x  = {1'b0, (delay_ff  == '0) ? CFG_W'(1) : delay_ff};
   assign period_x = {1'b0, (period_ff == '0) ? CFG_W'(1) : period_ff};

   assign age_inc  = cur_age + 1'b1;
   assign below    = age_inc < delay_x;
   assign over     = age_inc - delay_x;
   assign over_sub = over - period_x;
   assign lt_p     = over < period_x;
   assign lt_2p    = over_sub < period_x;

   always_comb begin
      priority if (below) begin
         fast_age  = age_inc;
         fire_fast = (age_inc == AGE_W'(1));
      end else if (lt_p) begin
         fast_age  = delay_x + over;
         fire_fast = (over == '0);
      end else begin
         fast_age  = delay_x + over_sub;
         fire_fast = (over_sub == '0);
      end
   end

   assign mod_age   = delay_x + {1'b0, rem_ff};
   assign new_age   = cmd.use_mod ? mod_age : fast_age;
   assign mod_trial = {rem_ff, dvd_ff[AGE_W-1]};

   assign mods = ((held_ff | latched_ff) & (M_SHIFT | M_CTRL | M_ALT))
               | (locked_ff & (M_CAPS | M_NUM));

   assign out_free = !rsp_valid_ff || !rsp_stall;
   assign push     = pend_valid_ff && (cmd.fire_take || cmd.flush);

   assign stat.at_end     = (idx_ff == cnt_ff);
   assign stat.match      = (cur_key == key_ff);
   assign stat.full       = (cnt_ff == CNT_W'(TABLE_DEPTH));
   assign stat.fast       = below || lt_p || lt_2p;
   assign stat.fire_fast  = fire_fast;
   assign stat.fire_mod   = (rem_ff == '0);
   assign stat.pend_valid = pend_valid_ff;
   assign stat.out_free   = out_free;

   always_comb begin
      cnt_in        = cnt_ff;
      idx_in        = idx_ff;
      held_in       = held_ff;
      latched_in    = latched_ff;
      locked_in     = locked_ff;
      delay_in      = delay_ff;
      period_in     = period_ff;
      pend_valid_in = pend_valid_ff;
      rsp_valid_in  = rsp_valid_ff;

      if (csr_write) begin
         if (csr_index == REG_REPEAT_DELAY) begin
            delay_in = csr_data;
         end
         if (csr_index == REG_REPEAT_PERIOD) begin
            period_in = csr_data;
         end
      end
      if (cmd.set_mods) begin
         held_in    = req_held_mods;
         latched_in = req_latched_mods;
         locked_in  = req_locked_mods;
      end
      if (cmd.clear_all) begin
         held_in    = '0;
         latched_in = '0;
         locked_in  = '0;
         cnt_in     = '0;
      end
      if (cmd.idx_clr) begin
         idx_in = '0;
      end else if (cmd.idx_inc) begin
         idx_in = idx_ff + 1'b1;
      end
      if (cmd.append) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (cmd.remove) begin
         cnt_in = cnt_ff - 1'b1;
      end

      if (cmd.fire_take) begin
         pend_valid_in = 1'b1;
      end else if (cmd.flush) begin
         pend_valid_in = 1'b0;
      end
      if (push) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff        <= '0;
         idx_ff        <= '0;
         held_ff       <= '0;
         latched_ff    <= '0;
         locked_ff     <= '0;
         delay_ff      <= DELAY_RESET;
         period_ff     <= PERIOD_RESET;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         cnt_ff        <= cnt_in;
         idx_ff        <= idx_in;
         held_ff       <= held_in;
         latched_ff    <= latched_in;
         locked_ff     <= locked_in;
         delay_ff      <= delay_in;
         period_ff     <= period_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // table storage: close the gap on removal, append at the tail
   always_ff @(posedge clock) begin
      if (cmd.remove) begin
         for (int j = 0; j < TABLE_DEPTH - 1; j++) begin
            if (CNT_W'(j) >= idx_ff) begin
               slot_ff[j] <= slot_ff[j+1];
               age_ff[j]  <= age_ff[j+1];
            end
         end
      end
      if (cmd.append) begin
         slot_ff[cnt_ff[SLOT_W-1:0]] <= key_ff;
         age_ff[cnt_ff[SLOT_W-1:0]]  <= '0;
      end
      if (cmd.age_wr) begin
         age_ff[sel] <= new_age;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         key_ff <= req_key_code;
      end
      if (cmd.mod_load) begin
         dvd_ff <= over;
         rem_ff <= '0;
      end else if (cmd.mod_step) begin
         dvd_ff <= {dvd_ff[AGE_W-2:0], 1'b0};
         if (mod_trial >= period_x) begin
            rem_ff <= CFG_W'(mod_trial - period_x);
         end else begin
            rem_ff <= mod_trial[CFG_W-1:0];
         end
      end
      if (cmd.fire_take) begin
         pend_key_ff   <= cur_key;
         pend_mods_ff  <= mods;
         pend_level_ff <= key_level(cur_key, mods);
      end
      if (push) begin
         rsp_key_ff   <= pend_key_ff;
         rsp_mods_ff  <= pend_mods_ff;
         rsp_level_ff <= pend_level_ff;
         rsp_last_ff  <= cmd.flush;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign rsp_out_key  = rsp_key_ff;
   assign rsp_out_mods = rsp_mods_ff;
   assign rsp_level    = rsp_level_ff;
   assign rsp_last     = rsp_last_ff;

endmodule
`default_nettype wire

/* hw/rtl/pressed_key_repeat_table.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pressed_key_repeat_table
// Held-key table with typematic auto-repeat and modifier tracking.
// ----------------------------------------------------------------------------
//   channel   direction  handshake              payload
//   req_      in         req_valid / req_stall  type, key code, three masks
//   rsp_      out        rsp_valid / rsp_stall  key, mods, level, last
//   csr_      in         csr_valid / csr_ready  index (0 delay, 1 period), data
//
// Modifier update, focus leave and unused codes are handled in idle, without a stall.
// Press and release walk the table to search for the key.
// Tick walks the table and ages every held key; a key whose age must be reduced
// by two periods or more (after a register change) goes through the modulo unit.
// Results sit in an output register; a stalled output holds the tick walk.
// Synchronous reset; no clearing pass.
// ----------------------------------------------------------------------------
module pressed_key_repeat_table import pkrt_pkg::*; #(
   parameter int TABLE_DEPTH = 6
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   input  wire logic [TYPE_W-1:0]    req_type,
   input  wire logic [KEY_W-1:0]     req_key_code,
   input  wire logic [MOD_W-1:0]     req_held_mods,
   input  wire logic [MOD_W-1:0]     req_latched_mods,
   input  wire logic [MOD_W-1:0]     req_locked_mods,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output logic [KEY_W-1:0]          rsp_out_key,
   output logic [MOD_W-1:0]          rsp_out_mods,
   output logic                      rsp_level,
   output logic                      rsp_last,
   input  wire logic                 csr_valid,
   output logic                      csr_ready,
   input  wire logic [CSR_IDX_W-1:0] csr_index,
   input  wire logic [CFG_W-1:0]     csr_data
);

   cmd_type  cmd;
   stat_type stat;

   assign csr_ready = 1'b1;

   pkrt_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_type  (req_type),
      .req_stall (req_stall),
      .stat      (stat),
      .cmd       (cmd)
   );

   pkrt_dp #(
      .TABLE_DEPTH (TABLE_DEPTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .stat             (stat),
      .req_key_code     (req_key_code),
      .req_held_mods    (req_held_mods),
      .req_latched_mods (req_latched_mods),
      .req_locked_mods  (req_locked_mods),
      .csr_write        (csr_valid && csr_ready),
      .csr_index        (csr_index),
      .csr_data         (csr_data),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_out_key      (rsp_out_key),
      .rsp_out_mods     (rsp_out_mods),
      .rsp_level        (rsp_level),
      .rsp_last         (rsp_last)
   );

endmodule
`default_nettype wire

/* hw/rtl/pkrt_chk.sv */
`default_nettype none
// ----------------------------------------------------------------------------
// pkrt_chk
// Port-level checks for the held-key repeat table.
// ----------------------------------------------------------------------------
module pkrt_chk import pkrt_pkg::*; (
   input wire logic              clock,
   input wire logic              reset,
   input wire logic              req_valid,
   input wire logic              req_stall,
   input wire logic [TYPE_W-1:0] req_type,
   input wire logic              rsp_valid,
   input wire logic              rsp_stall,
   input wire logic [KEY_W-1:0]  rsp_out_key,
   input wire logic [MOD_W-1:0]  rsp_out_mods,
   input wire logic              rsp_level,
   input wire logic              rsp_last
);

   logic keypad;
   assign keypad = (rsp_out_key >= KEYPAD_LO) && (rsp_out_key <= KEYPAD_HI);

   // stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_out_key)
         && $stable(rsp_out_mods) && $stable(rsp_level) && $stable(rsp_last))
      else $error("stalled response changed");

   a_reset_quiet: assert property (@(posedge clock)
      reset |=> !rsp_valid && !req_stall)
      else $error("response or stall active after reset");

   a_level: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (keypad ? (rsp_level == rsp_out_mods[4])
                            : (rsp_level == (rsp_out_mods[0] ^ rsp_out_mods[1]))))
      else $error("level does not match key and modifiers");

   // table walk requests always stall the next request
   a_walk_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall
         && (req_type == REQ_PRESS || req_type == REQ_RELEASE || req_type == REQ_TICK)
      |=> req_stall)
      else $error("walk request did not stall the next request");

   a_mods_single: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_type == REQ_MODS |=> !req_stall)
      else $error("modifier update took more than one cycle");

endmodule

bind pressed_key_repeat_table pkrt_chk u_pkrt_chk (
   .clock        (clock),
   .reset        (reset),
   .req_valid    (req_valid),
   .req_stall    (req_stall),
   .req_type     (req_type),
   .rsp_valid    (rsp_valid),
   .rsp_stall    (rsp_stall),
   .rsp_out_key  (rsp_out_key),
   .rsp_out_mods (rsp_out_mods),
   .rsp_level    (rsp_level),
   .rsp_last     (rsp_last)
);
`default_nettype wire
